// ----- design/hap_pkg.sv -----
// Shared types and constants for the HTTP alarm request parser.
`timescale 1ns / 1ps

package hap_pkg;

	// Time limits for a valid alarm setting
	localparam logic [7:0] ABSENT           = 8'd255;
	localparam logic [7:0] HOURS_PER_DAY    = 8'd24;
	localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;

	// Verdict codes
	typedef enum logic [1:0] {
		RESP_ERROR = 2'd0,
		RESP_OK    = 2'd1,
		RESP_PAGE  = 2'd2
	} resp_t;

	// Parser positions
	typedef enum logic [6:0] {
		POS_IDLE   = 7'd0,
		POS_LF     = 7'd20,
		POS_BLANK  = 7'd21,
		POS_H      = 7'd30,
		POS_H_EQ   = 7'd31,
		POS_H_D1   = 7'd32,
		POS_H_D2   = 7'd33,
		POS_M      = 7'd40,
		POS_M_EQ   = 7'd41,
		POS_M_D1   = 7'd42,
		POS_M_D2   = 7'd43,
		POS_G      = 7'd50,
		POS_GE     = 7'd51,
		POS_GET    = 7'd52,
		POS_P      = 7'd60,
		POS_PO     = 7'd61,
		POS_POS    = 7'd62,
		POS_POST   = 7'd63,
		POS_O      = 7'd70,
		POS_OF     = 7'd71,
		POS_OFF    = 7'd72
	} pos_t;

	// What one request has carried so far
	typedef struct packed {
		logic       saw_get;
		logic       saw_post;
		logic       saw_off;
		logic [7:0] hour;
		logic [7:0] minute;
	} req_t;

endpackage

// ----- design/hap_scan.sv -----
// Byte scanner: parser position and per-request registers.
`timescale 1ns / 1ps

module hap_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            kind,
	input  logic [7:0]      data_byte,
	output hap_pkg::req_t   req,
	output logic            done
);

	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_FF = 8'hFF;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_UE = 8'h45;
	localparam logic [7:0] CH_UG = 8'h47;
	localparam logic [7:0] CH_UO = 8'h4F;
	localparam logic [7:0] CH_UP = 8'h50;
	localparam logic [7:0] CH_US = 8'h53;
	localparam logic [7:0] CH_UT = 8'h54;
	localparam logic [7:0] CH_F  = 8'h66;
	localparam logic [7:0] CH_H  = 8'h68;
	localparam logic [7:0] CH_M  = 8'h6D;
	localparam logic [7:0] CH_O  = 8'h6F;

	hap_pkg::pos_t pos_q;
	hap_pkg::pos_t pos_nxt;
	hap_pkg::req_t req_q;
	logic          skip;
	logic          digit;
	logic [7:0]    dval;
	logic [7:0]    hour_x10;
	logic [7:0]    minute_x10;

	assign skip  = (data_byte == CH_FF) || (data_byte == CH_CR);
	assign digit = (data_byte >= CH_0) && (data_byte <= CH_9);
	assign dval  = data_byte - CH_0;
	assign hour_x10   = {req_q.hour[4:0], 3'b000} + {req_q.hour[6:0], 1'b0};
	assign minute_x10 = {req_q.minute[4:0], 3'b000} + {req_q.minute[6:0], 1'b0};

	// Step the position on one request byte
	always_comb begin
		pos_nxt = hap_pkg::POS_IDLE;
		if (data_byte == CH_NL) begin
			pos_nxt = (pos_q == hap_pkg::POS_LF) ? hap_pkg::POS_BLANK : hap_pkg::POS_LF;
		end else if (data_byte == CH_H) begin
			pos_nxt = hap_pkg::POS_H;
		end else if (data_byte == CH_EQ && pos_q == hap_pkg::POS_H) begin
			pos_nxt = hap_pkg::POS_H_EQ;
		end else if (data_byte == CH_M) begin
			pos_nxt = hap_pkg::POS_M;
		end else if (data_byte == CH_EQ && pos_q == hap_pkg::POS_M) begin
			pos_nxt = hap_pkg::POS_M_EQ;
		end else if (data_byte == CH_UG && pos_q == hap_pkg::POS_IDLE) begin
			pos_nxt = hap_pkg::POS_G;
		end else if (data_byte == CH_UE && pos_q == hap_pkg::POS_G) begin
			pos_nxt = hap_pkg::POS_GE;
		end else if (data_byte == CH_UT && pos_q == hap_pkg::POS_GE) begin
			pos_nxt = hap_pkg::POS_GET;
		end else if (data_byte == CH_UP && pos_q == hap_pkg::POS_IDLE) begin
			pos_nxt = hap_pkg::POS_P;
		end else if (data_byte == CH_UO && pos_q == hap_pkg::POS_P) begin
			pos_nxt = hap_pkg::POS_PO;
		end else if (data_byte == CH_US && pos_q == hap_pkg::POS_PO) begin
			pos_nxt = hap_pkg::POS_POS;
		end else if (data_byte == CH_UT && pos_q == hap_pkg::POS_POS) begin
			pos_nxt = hap_pkg::POS_POST;
		end else if (data_byte == CH_O) begin
			pos_nxt = hap_pkg::POS_O;
		end else if (data_byte == CH_F && pos_q == hap_pkg::POS_O) begin
			pos_nxt = hap_pkg::POS_OF;
		end else if (data_byte == CH_F && pos_q == hap_pkg::POS_OF) begin
			pos_nxt = hap_pkg::POS_OFF;
		end else if (digit) begin
			case (pos_q)
				hap_pkg::POS_H_EQ: pos_nxt = hap_pkg::POS_H_D1;
				hap_pkg::POS_H_D1: pos_nxt = hap_pkg::POS_H_D2;
				hap_pkg::POS_M_EQ: pos_nxt = hap_pkg::POS_M_D1;
				hap_pkg::POS_M_D1: pos_nxt = hap_pkg::POS_M_D2;
				default:           pos_nxt = hap_pkg::POS_IDLE;
			endcase
		end
	end

	// A request ends on a connection-end word or a blank line
	assign done = kind || (!skip && pos_nxt == hap_pkg::POS_BLANK);
	assign req  = req_q;

	// Update or clear the per-request registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= hap_pkg::POS_IDLE;
			req_q.saw_get  <= 1'b0;
			req_q.saw_post <= 1'b0;
			req_q.saw_off  <= 1'b0;
			req_q.hour     <= hap_pkg::ABSENT;
			req_q.minute   <= hap_pkg::ABSENT;
		end else if (fire) begin
			if (done) begin
				pos_q          <= hap_pkg::POS_IDLE;
				req_q.saw_get  <= 1'b0;
				req_q.saw_post <= 1'b0;
				req_q.saw_off  <= 1'b0;
				req_q.hour     <= hap_pkg::ABSENT;
				req_q.minute   <= hap_pkg::ABSENT;
			end else if (!skip) begin
				pos_q <= pos_nxt;
				case (pos_nxt)
					hap_pkg::POS_H_D1: req_q.hour     <= dval;
					hap_pkg::POS_H_D2: req_q.hour     <= hour_x10 + dval;
					hap_pkg::POS_M_D1: req_q.minute   <= dval;
					hap_pkg::POS_M_D2: req_q.minute   <= minute_x10 + dval;
					hap_pkg::POS_GET:  req_q.saw_get  <= 1'b1;
					hap_pkg::POS_POST: req_q.saw_post <= 1'b1;
					hap_pkg::POS_OFF:  req_q.saw_off  <= 1'b1;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- design/hap_verdict.sv -----
// Verdict logic and the stored alarm setting.
`timescale 1ns / 1ps

module hap_verdict (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            commit,
	input  hap_pkg::req_t   req,
	output hap_pkg::resp_t  response,
	output logic            alarm_enabled,
	output logic [4:0]      alarm_hour_out,
	output logic [5:0]      alarm_minute_out
);

	logic       alarm_on_q;
	logic [4:0] alarm_hour_q;
	logic [5:0] alarm_minute_q;
	logic       time_ok;

	assign time_ok = (req.hour < hap_pkg::HOURS_PER_DAY) &&
	                 (req.minute < hap_pkg::MINUTES_PER_HOUR);

	// Decide the verdict and the alarm setting it leaves behind
	always_comb begin
		response         = hap_pkg::RESP_ERROR;
		alarm_enabled    = alarm_on_q;
		alarm_hour_out   = alarm_hour_q;
		alarm_minute_out = alarm_minute_q;
		if (req.saw_post != req.saw_get) begin
			if (!req.saw_post) begin
				response = hap_pkg::RESP_PAGE;
			end else if (time_ok != req.saw_off) begin
				response = hap_pkg::RESP_OK;
				if (time_ok) begin
					alarm_enabled    = 1'b1;
					alarm_hour_out   = req.hour[4:0];
					alarm_minute_out = req.minute[5:0];
				end else begin
					alarm_enabled = 1'b0;
				end
			end
		end
	end

	// Store the alarm when a request ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_on_q     <= 1'b0;
			alarm_hour_q   <= '0;
			alarm_minute_q <= '0;
		end else if (commit) begin
			alarm_on_q     <= alarm_enabled;
			alarm_hour_q   <= alarm_hour_out;
			alarm_minute_q <= alarm_minute_out;
		end
	end

endmodule

// ----- design/http_alarm_request_parser_top.sv -----
// Top level of the HTTP alarm request parser.
`timescale 1ns / 1ps

// Takes one request word per cycle when in_stall is low (a byte, or a
// connection-end mark when kind is 1) and gives one verdict word per finished
// request: error, ok or settings page, with the stored alarm enable, hour and
// minute after that request. A word goes into an input register and is scanned
// from there; when it ends a request, its verdict is loaded into the output
// register as it is scanned and sits there from then on. With out_stall low a
// new word is taken every cycle. A verdict that is held back by out_stall holds
// the input register only when the next scanned word also ends a request. The
// alarm resets to off, 00:00.
module http_alarm_request_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] response,
	output logic       alarm_enabled,
	output logic [4:0] alarm_hour_out,
	output logic [5:0] alarm_minute_out
);

	logic           valid_s1;
	logic           kind_s1;
	logic [7:0]     byte_s1;
	logic           fire_s1;
	logic           done_s1;
	logic           out_valid_q;
	logic [1:0]     response_q;
	logic           enabled_q;
	logic [4:0]     hour_q;
	logic [5:0]     minute_q;
	hap_pkg::req_t  req;
	hap_pkg::resp_t resp_nxt;
	logic           enabled_nxt;
	logic [4:0]     hour_nxt;
	logic [5:0]     minute_nxt;

	// Scan the held word unless its verdict has nowhere to go
	assign fire_s1  = valid_s1 && (!done_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
	end

	hap_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.req       (req),
		.done      (done_s1)
	);

	hap_verdict u_verdict (
		.clk              (clk),
		.arst_n           (arst_n),
		.commit           (fire_s1 && done_s1),
		.req              (req),
		.response         (resp_nxt),
		.alarm_enabled    (enabled_nxt),
		.alarm_hour_out   (hour_nxt),
		.alarm_minute_out (minute_nxt)
	);

	// Output register: load a verdict, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && done_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && done_s1) begin
			response_q <= resp_nxt;
			enabled_q  <= enabled_nxt;
			hour_q     <= hour_nxt;
			minute_q   <= minute_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign response         = response_q;
	assign alarm_enabled    = enabled_q;
	assign alarm_hour_out   = hour_q;
	assign alarm_minute_out = minute_q;

	// A held word is never lost while it waits
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |=> valid_s1)
		else $error("held word dropped");

	// Stall only with a word in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && done_s1 && out_valid_q)
		else $error("input stalled without cause");

	// A verdict code is always one of the three defined ones
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (response_q == hap_pkg::RESP_ERROR ||
		                 response_q == hap_pkg::RESP_OK ||
		                 response_q == hap_pkg::RESP_PAGE))
		else $error("bad verdict code");

	// The stored alarm is always a real time of day
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> hour_q < 5'd24 && minute_q < 6'd60)
		else $error("alarm time out of range");

	// An ok verdict with a valid time reports the alarm on
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && done_s1 && resp_nxt == hap_pkg::RESP_OK && !req.saw_off
		|=> enabled_q)
		else $error("alarm not enabled after setting a time");

endmodule
